[rtl/core/pvqm_pkg.sv]
// Package for the pot volume quantizer with motor tracking.
// Holds widths, item kind and register index codes and the sequencer state type.
// No dependencies.
package pvqm_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int VOL_BITS    = 10;
    localparam int STEP_BITS   = 10;
    localparam int DZ_BITS     = 9;

    // Working width for compares between quotient, level and sample.
    localparam int QW = (SAMPLE_BITS > VOL_BITS) ? SAMPLE_BITS : VOL_BITS;
    localparam int CNT_BITS = $clog2(SAMPLE_BITS);

    localparam logic [VOL_BITS-1:0]  VOL_MAX        = '1;
    localparam logic [STEP_BITS-1:0] STEP_RESET     = STEP_BITS'(64);
    localparam logic [DZ_BITS-1:0]   DZ_RESET       = DZ_BITS'(8);

    // input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TARGET = 1'b1;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEADZONE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

endpackage

[rtl/core/pvqm_if.sv]
// Valid/ready channel interfaces for the pot volume quantizer.
// Depends on pvqm_pkg for field widths.
interface pvqm_in_if;
    import pvqm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic [VOL_BITS-1:0]    target_volume;

    modport source (output valid, kind, adc_sample, target_volume, input ready);
    modport sink   (input valid, kind, adc_sample, target_volume, output ready);
endinterface

interface pvqm_out_if;
    import pvqm_pkg::*;
    logic                valid;
    logic                ready;
    logic [VOL_BITS-1:0] volume_out;
    logic                sample_valid;
    logic                drive_down;
    logic                drive_up;
    logic                motor_busy;

    modport source (output valid, volume_out, sample_valid, drive_down, drive_up,
                    motor_busy, input ready);
    modport sink   (input valid, volume_out, sample_valid, drive_down, drive_up,
                    motor_busy, output ready);
endinterface

interface pvqm_cfg_if;
    import pvqm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [STEP_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/pot_volume_quantizer_motor_top.sv]
// A sample is divided by the restoring divider, one quotient bit per cycle, then passes a
// finish state; a set-target goes straight to the finish state.
// One item at a time: the next input is taken while a result waits, and an item stalls only
// in its finish state, until the output is free.
// Reset (synchronous, active low): volume, last sample, motor and drives clear; step size
// register to 64, dead zone to 8. No clearing pass. Uses pvqm_pkg and pvqm_if.sv.
module pot_volume_quantizer_motor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pvqm_in_if.sink     i_in,
    pvqm_out_if.source  o_out,
    pvqm_cfg_if.sink    i_cfg
);
    import pvqm_pkg::*;

    // configuration
    logic [STEP_BITS-1:0]   r_step;
    logic [DZ_BITS-1:0]     r_dz;

    // sequencer
    t_state                 r_state, n_state;
    logic [CNT_BITS-1:0]    r_cnt;

    // captured item
    logic                   r_kind;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [VOL_BITS-1:0]    r_target;

    // divider: r_quo starts as the dividend and shifts quotient bits in from the right
    logic [SAMPLE_BITS-1:0] r_quo;
    logic [STEP_BITS-1:0]   r_rem;
    logic [STEP_BITS-1:0]   r_div;
    logic [STEP_BITS:0]     trial;
    logic                   fits;

    // block state, also the result payload
    logic [VOL_BITS-1:0]    r_volume, n_volume;
    logic [VOL_BITS-1:0]    r_last, n_last;
    logic                   r_motor, n_motor;
    logic                   r_down, n_down;
    logic                   r_up, n_up;
    logic                   r_ok, n_ok;
    logic                   r_out_valid;

    logic                   out_free;
    logic                   fin_go;
    logic [QW-1:0]          q_ext;
    logic [VOL_BITS-1:0]    level;
    logic                   q_ok;

    assign out_free = !r_out_valid || o_out.ready;
    assign fin_go   = (r_state == ST_FIN) && out_free;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // one restoring step
    assign trial = {r_rem, r_quo[SAMPLE_BITS-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // quotient check: zero quotient means sample below one step, always valid
    assign q_ext = QW'(r_quo);
    assign level = (q_ext > QW'(VOL_MAX)) ? VOL_MAX : q_ext[VOL_BITS-1:0];
    assign q_ok  = (r_quo == '0) || (r_rem >= {1'b0, r_dz});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.kind == KIND_TARGET) ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state update for a finished item
    always_comb begin
        n_volume = r_volume;
        n_last   = r_last;
        n_motor  = r_motor;
        n_down   = r_down;
        n_up     = r_up;
        n_ok     = 1'b0;
        if (r_kind == KIND_TARGET) begin
            n_volume = r_target;
            n_motor  = 1'b1;
        end else begin
            n_ok = q_ok;
            if (r_motor) begin
                if (q_ok) begin
                    priority if (r_volume > level) begin
                        n_down = 1'b1;
                        n_up   = 1'b0;
                    end else if (r_volume < level) begin
                        n_down = 1'b0;
                        n_up   = 1'b1;
                    end else begin
                        n_down  = 1'b0;
                        n_up    = 1'b0;
                        n_motor = 1'b0;
                    end
                end
                // dead-zone sample in motor mode: drives hold
            end else if (QW'(r_sample) != QW'(r_last)) begin
                if (q_ok) begin
                    n_volume = level;
                end
                n_last = VOL_BITS'(QW'(r_sample));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_RESET;
            r_dz        <= DZ_RESET;
            r_volume    <= '0;
            r_last      <= '0;
            r_motor     <= 1'b0;
            r_down      <= 1'b0;
            r_up        <= 1'b0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_STEP_SIZE: r_step <= i_cfg.data;
                    CFG_DEADZONE:  r_dz   <= i_cfg.data[DZ_BITS-1:0];
                    default:       r_step <= r_step;
                endcase
            end

            if (fin_go) begin
                r_volume    <= n_volume;
                r_last      <= n_last;
                r_motor     <= n_motor;
                r_down      <= n_down;
                r_up        <= n_up;
                r_ok        <= n_ok;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind   <= i_in.kind;
            r_sample <= i_in.adc_sample;
            r_target <= i_in.target_volume;
            r_quo    <= i_in.adc_sample;
            r_rem    <= '0;
            r_cnt    <= CNT_BITS'(SAMPLE_BITS - 1);
            // zero step size divides as one
            r_div    <= (r_step == '0) ? STEP_BITS'(1) : r_step;
        end else if (r_state == ST_DIV) begin
            r_quo <= {r_quo[SAMPLE_BITS-2:0], fits};
            r_rem <= fits ? STEP_BITS'(trial - {1'b0, r_div}) : trial[STEP_BITS-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.volume_out   = r_volume;
    assign o_out.sample_valid = r_ok;
    assign o_out.drive_down   = r_down;
    assign o_out.drive_up     = r_up;
    assign o_out.motor_busy   = r_motor;

endmodule
